// ===== rtl/core/vbpd_pkg.sv =====
// ----------------------------------------------------------------------------
// vbpd_pkg
// Shared types and constants of the video byte pixel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package vbpd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned ROW_W   = 8;
	localparam int unsigned COL_W   = 6;
	localparam int unsigned PAL_W   = 7;
	localparam int unsigned ADDR_W  = 17;
	localparam int unsigned PIX_W   = 3;
	localparam int unsigned NUM_PIX = 4;

	localparam int unsigned IN_TDATA_W  = 24;
	localparam int unsigned OUT_TDATA_W = 32;
	localparam int unsigned CFG_IDX_W   = 2;

	// Frame geometry
	localparam logic [ADDR_W-1:0] LINE_W_BORDER     = 17'd261;
	localparam logic [ADDR_W-1:0] TOP_OFFSET_BORDER = 17'd25;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PALETTE     = 2'd0,
		REG_COLOR_MODE  = 2'd1,
		REG_SHOW_BORDER = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [PAL_W-1:0] palette;
		logic             color_mode;
		logic             show_border;
	} cfg_t;

	typedef logic [NUM_PIX-1:0][PIX_W-1:0] pix_vec_t;

endpackage

`default_nettype wire

// ===== rtl/core/vbpd_decode.sv =====
// ----------------------------------------------------------------------------
// vbpd_decode
// Combinational decode of one video byte: four pixel color indices and the
// frame buffer address of the leftmost pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module vbpd_decode (
	input  var vbpd_pkg::cfg_t                      cfg,
	input  wire logic [vbpd_pkg::BYTE_W-1:0]        screen_byte,
	input  wire logic [vbpd_pkg::ROW_W-1:0]         row,
	input  wire logic [vbpd_pkg::COL_W-1:0]         col,
	output logic      [vbpd_pkg::ADDR_W-1:0]        pixel_addr,
	output vbpd_pkg::pix_vec_t                      pix
);

	// Map a two-bit color pair to an RGB index under the palette bits
	function automatic logic [vbpd_pkg::PIX_W-1:0] pair_to_rgb(
		input logic [1:0]                 c,
		input logic [vbpd_pkg::PAL_W-1:0] p
	);
		logic r, g, b;
		begin
			case (c)
				2'd0: begin
					r = (p[3] == p[4]);
					g = p[5];
					b = (p[2] == p[6]);
				end
				2'd1: begin
					r = (p[0] == p[4]);
					g = p[5];
					b = ~p[6];
				end
				2'd2: begin
					r = p[4];
					g = ~p[5];
					b = p[6];
				end
				default: begin
					r = ~p[4];
					g = (p[1] == p[5]);
					b = p[6];
				end
			endcase
			pair_to_rgb = {r, g, b};
		end
	endfunction

	logic [vbpd_pkg::ADDR_W-1:0] row_off;

	always_comb begin
		row_off = vbpd_pkg::ADDR_W'(row) + vbpd_pkg::TOP_OFFSET_BORDER;
		if (cfg.show_border) begin
			// constant multiply: synthesis folds it into shifts and adds
			pixel_addr = vbpd_pkg::ADDR_W'(row_off * vbpd_pkg::LINE_W_BORDER)
				+ vbpd_pkg::ADDR_W'({col, 2'b00});
		end else begin
			pixel_addr = {1'b0, row, col, 2'b00};
		end
	end

	// Pixel p: high bit from byte bit 7-p, low bit from byte bit 3-p
	always_comb begin
		for (int p = 0; p < vbpd_pkg::NUM_PIX; p++) begin
			if (cfg.color_mode) begin
				pix[p] = pair_to_rgb({screen_byte[7-p], screen_byte[3-p]}, cfg.palette);
			end else begin
				pix[p] = {1'b0, screen_byte[7-p], screen_byte[3-p]};
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/video_byte_pixel_decoder_core.sv =====
// ----------------------------------------------------------------------------
// video_byte_pixel_decoder_core
// Turns video memory bytes into four pixel color indices plus the frame
// buffer address of the first pixel.
// ----------------------------------------------------------------------------
// Each transfer on the slave stream carries one video byte with its screen
// line and byte column; exactly one result transfer follows on the master
// stream, in order. The block takes one byte per clock cycle while the sink
// keeps up: the byte is captured in an input register, decoded by the
// palette logic and the constant-multiply address adder, and held in a
// result register until the sink takes it. Each stage advances when the one
// after it has room, so a stalled sink stops the input only when both
// registers are full. Pixel p
// (0 = leftmost) uses byte bits 7-p and 3-p as its color pair. In color mode
// the pair and the seven palette bits give an RGB index r<<2|g<<1|b; in mono
// mode the pair itself is the index. With show_border set the frame is 261
// pixels wide and lines start 25 lines down; otherwise it is 256 wide with no
// offset. Configuration writes take effect at once and belong to idle time.
`default_nettype none

module video_byte_pixel_decoder_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,

	// configuration write port
	input  wire logic                                  cfg_we,
	input  wire logic [vbpd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [vbpd_pkg::PAL_W-1:0]            cfg_data,

	// input stream
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// tdata from bit 0: screen_byte[7:0], row[15:8], col[21:16], zero pad
	input  wire logic [vbpd_pkg::IN_TDATA_W-1:0]       s_axis_tdata,

	// result stream
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// tdata from bit 0: pixel_addr[16:0], pix0[19:17], pix1[22:20],
	// pix2[25:23], pix3[28:26], zero pad
	output logic      [vbpd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

	// Configuration registers
	vbpd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.palette     <= '0;
			cfg_q.color_mode  <= 1'b1;
			cfg_q.show_border <= 1'b0;
		end else if (cfg_we) begin
			// writes beyond the register list are dropped
			case (vbpd_pkg::cfg_reg_t'(cfg_index))
				vbpd_pkg::REG_PALETTE:     cfg_q.palette     <= cfg_data;
				vbpd_pkg::REG_COLOR_MODE:  cfg_q.color_mode  <= cfg_data[0];
				vbpd_pkg::REG_SHOW_BORDER: cfg_q.show_border <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Pipeline control: a stage advances when the stage after it is empty
	// or is being drained in this cycle.
	logic valid_s1, valid_s2;
	logic adv_s2, adv_s1;

	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;
	assign m_axis_tvalid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage 1: capture the incoming item
	logic [vbpd_pkg::BYTE_W-1:0] byte_s1;
	logic [vbpd_pkg::ROW_W-1:0]  row_s1;
	logic [vbpd_pkg::COL_W-1:0]  col_s1;

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata[7:0];
			row_s1  <= s_axis_tdata[15:8];
			col_s1  <= s_axis_tdata[21:16];
		end
	end

	// Decode between the two registers
	logic [vbpd_pkg::ADDR_W-1:0] addr_d;
	vbpd_pkg::pix_vec_t          pix_d;

	vbpd_decode u_decode (
		.cfg         (cfg_q),
		.screen_byte (byte_s1),
		.row         (row_s1),
		.col         (col_s1),
		.pixel_addr  (addr_d),
		.pix         (pix_d)
	);

	// Stage 2: hold the result until the sink takes it
	logic [vbpd_pkg::ADDR_W-1:0] addr_s2;
	vbpd_pkg::pix_vec_t          pix_s2;

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			addr_s2 <= addr_d;
			pix_s2  <= pix_d;
		end
	end

	assign m_axis_tdata = {3'b000, pix_s2[3], pix_s2[2], pix_s2[1], pix_s2[0], addr_s2};

endmodule

`default_nettype wire
